>>> rtl/core/estw_pkg.sv
// shared types and constants for the edge span table walker
package estw_pkg;

  localparam int unsigned COORD_W = 10;

  typedef enum logic [0:0] {
    KIND_EDGE = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word and set up walk
    logic clr_step;   // clearing pass advance
    logic div_start;  // start quotient for current step
    logic div_step;   // one quotient bit
    logic rd;         // issue table read
    logic wr;         // write back merged row (emptied row on a read)
    logic advance;    // next pixel along major axis
    logic out_load;   // capture read result
  } estw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic div_busy;
    logic need_div;
    logic last_pix;
  } estw_sts_t;

endpackage

>>> rtl/core/estw_if.sv
// valid/ready channel interfaces
interface estw_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] kind;
  logic [9:0] start_x;
  logic [9:0] start_y;
  logic [9:0] end_x;
  logic [9:0] end_y;
  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface estw_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] span_left;
  logic [9:0] span_right;
  logic [0:0] span_valid;
  modport source (output valid, span_left, span_right, span_valid, input ready);
  modport sink (input valid, span_left, span_right, span_valid, output ready);
endinterface

>>> rtl/core/estw_ram.sv
// generic single port ram with registered read
module estw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

>>> rtl/core/estw_ctrl.sv
// controller state machine
module estw_ctrl import estw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  estw_sts_t sts,
  output estw_cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.is_read || !sts.need_div) begin
          cmd.rd = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.div_busy) cmd.div_step = 1'b1;
        else begin
          cmd.rd = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: state_nxt = ST_WR;
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.is_read) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_OUT;
        end else if (sts.last_pix) state_nxt = ST_IDLE;
        else begin
          cmd.advance = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_nxt = ST_DIV;
          end else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

>>> rtl/core/estw_dp.sv
// datapath: walk setup, quotient divider, row table merge
module estw_dp import estw_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  estw_cmd_t         cmd,
  output estw_sts_t         sts,
  input  logic [0:0]        in_kind,
  input  logic [9:0]        in_start_x,
  input  logic [9:0]        in_start_y,
  input  logic [9:0]        in_end_x,
  input  logic [9:0]        in_end_y,
  output logic [9:0]        span_left,
  output logic [9:0]        span_right,
  output logic [0:0]        span_valid
);
  localparam int AW = $clog2(SCREEN_HEIGHT);
  localparam int PW = 20;  // product width
  localparam logic [10:0] EMPTY = 11'h7FF;

  // walk state
  logic       is_read_r;
  logic       xmaj_r;      // walk along columns
  logic       neg_r;       // minor delta negative
  logic       need_div_r;  // diagonal walk
  logic       horiz_r;
  logic [9:0] ma0_r, mi0_r, ma_end_r;
  logic [9:0] dmaj_r, dmin_r;
  logic [9:0] step_r;      // index along major axis
  logic [9:0] q_r;         // quotient
  // divider
  logic [PW-1:0] num_r;
  logic [10:0]   rem_r;
  logic [4:0]    dcnt_r;
  logic          dbusy_r;
  // clearing pass
  logic [AW:0]   clr_r;
  // table
  logic [AW-1:0] addr;
  logic          we;
  logic [10:0]   wl, rl;
  logic [9:0]    wr_, rr;
  logic [9:0]    px, py;
  logic          on_screen;

  estw_ram #(.WIDTH(11), .DEPTH(SCREEN_HEIGHT)) u_left (
    .clk(clk), .we(we), .addr(addr), .wdata(wl), .re(cmd.rd), .rdata(rl));
  estw_ram #(.WIDTH(10), .DEPTH(SCREEN_HEIGHT)) u_right (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_), .re(cmd.rd), .rdata(rr));

  logic       swx, swy;
  logic [9:0] adx, ady;
  always_comb begin
    adx = (in_end_x > in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
    ady = (in_end_y > in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
    swx = in_start_x > in_end_x;
    swy = in_start_y > in_end_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      dbusy_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.div_start) dbusy_r <= 1'b1;
      else if (cmd.div_step && dcnt_r == 5'd0) dbusy_r <= 1'b0;
    end
    if (cmd.load) begin
      is_read_r <= (in_kind == KIND_READ);
      step_r <= '0;
      horiz_r <= (ady == 10'd0) && (adx != 10'd0);
      if (in_kind == KIND_READ) begin
        xmaj_r <= 1'b0;
        need_div_r <= 1'b0;
        ma0_r <= in_start_y;
        mi0_r <= in_start_y;
      end else if (ady == 10'd0 && adx != 10'd0) begin
        // horizontal: left end then right end on the same row
        xmaj_r <= 1'b1;
        need_div_r <= 1'b0;
        ma0_r <= (in_start_x < in_end_x) ? in_start_x : in_end_x;
        ma_end_r <= (in_start_x < in_end_x) ? in_end_x : in_start_x;
        mi0_r <= in_start_y;
        dmaj_r <= 10'd1;
        dmin_r <= '0;
        neg_r <= 1'b0;
      end else if (adx == 10'd0) begin
        xmaj_r <= 1'b0;
        need_div_r <= 1'b0;
        ma0_r <= (in_start_y < in_end_y) ? in_start_y : in_end_y;
        ma_end_r <= (in_start_y < in_end_y) ? in_end_y : in_start_y;
        mi0_r <= in_start_x;
        dmaj_r <= ady;
        dmin_r <= '0;
        neg_r <= 1'b0;
      end else if (adx >= ady) begin
        xmaj_r <= 1'b1;
        need_div_r <= 1'b1;
        ma0_r <= swx ? in_end_x : in_start_x;
        ma_end_r <= swx ? in_start_x : in_end_x;
        mi0_r <= swx ? in_end_y : in_start_y;
        dmaj_r <= adx;
        dmin_r <= ady;
        neg_r <= swx ? (in_start_y < in_end_y) : (in_end_y < in_start_y);
      end else begin
        xmaj_r <= 1'b0;
        need_div_r <= 1'b1;
        ma0_r <= swy ? in_end_y : in_start_y;
        ma_end_r <= swy ? in_start_y : in_end_y;
        mi0_r <= swy ? in_end_x : in_start_x;
        dmaj_r <= ady;
        dmin_r <= adx;
        neg_r <= swy ? (in_start_x < in_end_x) : (in_end_x < in_start_x);
      end
    end
    if (cmd.advance) step_r <= horiz_r ? ma_end_r - ma0_r : step_r + 1'b1;
    // restoring divide of dmin*step by dmaj, magnitudes only
    if (cmd.div_start) begin
      num_r <= dmin_r * step_r;
      rem_r <= '0;
      dcnt_r <= 5'(PW - 1);
      q_r <= '0;
    end else if (cmd.div_step) begin
      logic [11:0] trial;
      trial = {rem_r, num_r[PW-1]} - {2'b00, dmaj_r};
      num_r <= {num_r[PW-2:0], 1'b0};
      if (!trial[11]) begin
        rem_r <= trial[10:0];
        q_r <= {q_r[8:0], 1'b1};
      end else begin
        rem_r <= {rem_r[9:0], num_r[PW-1]};
        q_r <= {q_r[8:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end else if (cmd.load || cmd.advance) q_r <= '0;
  end

  // current pixel
  logic [9:0] ma, mi;
  always_comb begin
    ma = ma0_r + step_r;
    mi = neg_r ? mi0_r - q_r : mi0_r + q_r;
    px = xmaj_r ? ma : mi;
    py = xmaj_r ? mi : ma;
    if (is_read_r) begin
      px = '0;
      py = ma0_r;
    end
    on_screen = (32'(px) < SCREEN_WIDTH) && (32'(py) < SCREEN_HEIGHT);
  end

  always_comb begin
    if (cmd.clr_step) begin
      addr = clr_r[AW-1:0];
      we = 1'b1;
      wl = EMPTY;
      wr_ = '0;
    end else begin
      addr = AW'(py);
      we = cmd.wr && on_screen;
      if (is_read_r) begin
        wl = EMPTY;
        wr_ = '0;
      end else begin
        wl = (rl == EMPTY || rl > {1'b0, px}) ? {1'b0, px} : rl;
        wr_ = (rr < px) ? px : rr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (on_screen && rl != EMPTY) begin
        span_left <= rl[9:0];
        span_right <= rr;
        span_valid <= 1'b1;
      end else begin
        span_left <= '0;
        span_right <= '0;
        span_valid <= 1'b0;
      end
    end
  end

  assign sts.clr_done = (clr_r == (AW+1)'(SCREEN_HEIGHT - 1));
  assign sts.is_read = is_read_r;
  assign sts.div_busy = dbusy_r;
  assign sts.need_div = need_div_r;
  assign sts.last_pix = (ma == ma_end_r);
endmodule

>>> rtl/core/edge_span_table_walker.sv
// top level of the edge span table walker
// a diagonal walk computes a quotient per pixel, then a table read-modify-write
// axis-aligned edges skip the quotient; a read result is registered at write-back
// the result register holds one word; the next item is taken as it leaves
// after reset a clearing pass empties every row of the row table
// before the first item is accepted
module edge_span_table_walker import estw_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input logic     clk,
  input logic     rst_n,
  estw_in_if.sink  in_ch,
  estw_out_if.source out_ch
);
  estw_cmd_t cmd;
  estw_sts_t sts;

  estw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd));

  estw_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_ch.kind), .in_start_x(in_ch.start_x), .in_start_y(in_ch.start_y),
    .in_end_x(in_ch.end_x), .in_end_y(in_ch.end_y),
    .span_left(out_ch.span_left), .span_right(out_ch.span_right),
    .span_valid(out_ch.span_valid));
endmodule

>>> test/estw_span_checker.sv
// span table predictor and result checker for the edge span table walker
`timescale 1ns / 1ps
module estw_span_checker import estw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  estw_in_if          in_ch,
  estw_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending_spans,
  output int unsigned span_count
);

  localparam int ROWS = 1024;
  localparam int COLS = 1024;
  localparam logic [10:0] ROW_EMPTY = 11'd2047;

  typedef struct packed {
    logic [9:0] left;
    logic [9:0] right;
    logic       valid;
  } span_t;

  logic [10:0] tbl_left [ROWS];
  logic [9:0]  tbl_right [ROWS];
  span_t       span_q[$];

  assign pending_spans = span_q.size();

  task automatic report(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch %s: got %0d expected %0d (span %0d)", what, got, want, span_count);
  endtask

  task automatic mark_pixel(input int x, input int y);
    if (x < 0 || y < 0 || x >= COLS || y >= ROWS) return;
    if (tbl_left[y] == ROW_EMPTY || int'(tbl_left[y]) > x) tbl_left[y] = x[10:0];
    if (int'(tbl_right[y]) < x) tbl_right[y] = x[9:0];
  endtask

  task automatic trace_edge(input int x1, input int y1, input int x2, input int y2);
    int dx, dy, i, t;
    dx = x2 > x1 ? x2 - x1 : x1 - x2;
    dy = y2 > y1 ? y2 - y1 : y1 - y2;
    if (dx == 0 && dy == 0) begin
      mark_pixel(x1, y1);
    end else if (dx == 0) begin
      for (i = (y1 < y2 ? y1 : y2); i <= (y1 < y2 ? y2 : y1); i++) mark_pixel(x1, i);
    end else if (dy == 0) begin
      mark_pixel(x1 < x2 ? x1 : x2, y1);
      mark_pixel(x1 < x2 ? x2 : x1, y1);
    end else begin
      // walk the longer axis from its smaller end, ties go along columns
      if ((dx >= dy && x1 > x2) || (dx < dy && y1 > y2)) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      if (dx >= dy) begin
        for (i = x1; i <= x2; i++) mark_pixel(i, y1 + ((y2 - y1) * (i - x1)) / (x2 - x1));
      end else begin
        for (i = y1; i <= y2; i++) mark_pixel(x1 + ((x2 - x1) * (i - y1)) / (y2 - y1), i);
      end
    end
  endtask

  always @(posedge clk) begin
    span_t got, want;
    int row;
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        tbl_left[r] = ROW_EMPTY;
        tbl_right[r] = '0;
      end
      span_q.delete();
      fail_count = 0;
      span_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (kind_t'(in_ch.kind) == KIND_EDGE) begin
          trace_edge(in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y);
        end else begin
          row = in_ch.start_y;
          want = '0;
          if (row < ROWS) begin
            if (tbl_left[row] != ROW_EMPTY) want = '{tbl_left[row][9:0], tbl_right[row], 1'b1};
            tbl_left[row] = ROW_EMPTY;
            tbl_right[row] = '0;
          end
          span_q.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.span_left, out_ch.span_right, out_ch.span_valid};
        span_count++;
        if (span_q.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          want = span_q.pop_front();
          if (got.valid != want.valid) report("span_valid", got.valid, want.valid);
          if (got.left != want.left) report("span_left", got.left, want.left);
          if (got.right != want.right) report("span_right", got.right, want.right);
        end
      end
    end
  end

endmodule

>>> test/edge_span_table_walker_tb.sv
// stimulus and verdict for the edge span table walker
`timescale 1ns / 1ps
module edge_span_table_walker_tb import estw_pkg::*;;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned fail_count, pending_spans, span_count;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 1'b0;
  int edge_words = 0, read_words = 0;

  estw_in_if  in_ch();
  estw_out_if out_ch();

  edge_span_table_walker u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  estw_span_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_spans(pending_spans), .span_count(span_count)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_EDGE;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // valid stays up between back-to-back words and drops only while idling
  task automatic send_word(input kind_t k, input int sx, input int sy, input int ex, input int ey);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.start_x <= sx[9:0];
    in_ch.start_y <= sy[9:0];
    in_ch.end_x <= ex[9:0];
    in_ch.end_y <= ey[9:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (k == KIND_EDGE) edge_words++;
    else read_words++;
  endtask

  // random edge in a small band of rows, mostly short so walks stay cheap
  task automatic rand_edge(input int base);
    int sx, sy, len;
    sx = $urandom_range(1023);
    sy = base + $urandom_range(7);
    len = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(12);
    case ($urandom_range(3))
      0: send_word(KIND_EDGE, sx, sy, $urandom_range(1023), sy);
      1: send_word(KIND_EDGE, sx, sy, sx, (sy + $urandom_range(10)) % 1024);
      default: send_word(KIND_EDGE, sx, sy,
                         (sx + ($urandom_range(1) ? len : -len)) & 1023,
                         (sy + $urandom_range(len)) & 1023);
    endcase
  endtask

  initial begin
    int base;
    int ne;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, point, horizontal both orders, vertical, diagonals
    send_word(KIND_READ, 0, 0, 0, 0);
    send_word(KIND_EDGE, 0, 0, 0, 0);
    send_word(KIND_READ, 1023, 0, 1023, 1023);
    send_word(KIND_READ, 0, 0, 0, 0);
    send_word(KIND_EDGE, 900, 5, 3, 5);
    send_word(KIND_EDGE, 1, 5, 1023, 5);
    send_word(KIND_READ, 0, 5, 0, 0);
    send_word(KIND_EDGE, 1023, 1023, 1023, 1016);
    send_word(KIND_READ, 0, 1023, 0, 0);
    send_word(KIND_READ, 0, 1020, 0, 0);
    send_word(KIND_EDGE, 10, 20, 0, 30);
    send_word(KIND_EDGE, 40, 20, 43, 27);
    send_word(KIND_EDGE, 50, 30, 45, 22);
    for (int r = 20; r <= 30; r++) send_word(KIND_READ, 0, r, 0, 0);
    send_word(KIND_EDGE, 682, 341, 0, 0);
    send_word(KIND_READ, 0, 341, 0, 0);
    send_word(KIND_READ, 0, 1, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        3: begin send_idle = 11; recv_stall = 11; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int n = 0; n < 12; n++) begin
        base = $urandom_range(1016);
        if (ph == 4 && n == 0) hold_off = 1'b1;
        ne = $urandom_range(6, 2);
        for (int e = 0; e < ne; e++) rand_edge(base);
        for (int r = 0; r < 4; r++) send_word(KIND_READ, 0, base + $urandom_range(7), 0, 0);
        if ($urandom_range(3) == 0) begin
          send_word(KIND_EDGE, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023), $urandom_range(1023));
          send_word(KIND_READ, 0, $urandom_range(1023), 0, 0);
        end
      end
    end
    in_ch.valid <= 1'b0;
    hold_off = 1'b0;

    while (pending_spans != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d edge words and %0d read words, %0d spans checked",
             edge_words, read_words, span_count);
    $display("covered points, axis-aligned and diagonal edges, off-edge reads and stalls");
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // long receiver hold-off while edges keep coming
  initial begin
    wait (hold_off);
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #400ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/estw_pkg.sv
rtl/core/estw_if.sv
rtl/core/estw_ram.sv
rtl/core/estw_ctrl.sv
rtl/core/estw_dp.sv
rtl/core/edge_span_table_walker.sv
test/estw_span_checker.sv
test/edge_span_table_walker_tb.sv
